[hdl/tpss_pkg.sv]
package tpss_pkg;

  localparam int MAX_STEPS     = 64;
  localparam int TABLE_COLUMNS = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int STEP_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int COL_W   = $clog2(TABLE_COLUMNS);
  localparam int ROWX_W  = (STEP_W > 6) ? STEP_W : 6;
  localparam int COLX_W  = (COL_W > 4) ? COL_W : 4;
  localparam int ADDR_W  = $clog2(MAX_STEPS * TABLE_COLUMNS);
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  localparam int CMP_W   = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PANEL_W = 4;
  localparam int TIME_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [15:0] POS_NONE  = 16'd0;
  localparam logic [15:0] POS_OPEN  = 16'd1;
  localparam logic [15:0] POS_CLOSE = 16'd2;

  localparam logic [1:0] ACT_NO_MOVE = 2'd0;
  localparam logic [1:0] ACT_OPEN    = 2'd1;
  localparam logic [1:0] ACT_CLOSE   = 2'd2;
  localparam logic [1:0] ACT_DETACH  = 2'd3;

  localparam logic KIND_PANEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PANEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PANEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LEVEL = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  step_index;
    logic [3:0]  column;
    logic [15:0] word;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] panel;
    logic [1:0] action;
    logic [2:0] speed;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        in_range;
    logic [5:0]  row;
    logic [3:0]  col;
    logic [15:0] word;
  } cmd_t;

  typedef struct packed {
    logic [6:0] step_count;
    logic [3:0] first_panel;
    logic [3:0] last_panel;
    logic [2:0] speed_level;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(logic [ROWX_W-1:0] row,
                                                 logic [COLX_W-1:0] col);
    tbl_addr = ADDR_W'(int'(row) * TABLE_COLUMNS + int'(col));
  endfunction

endpackage

[hdl/tpss_front.sv]
module tpss_front import tpss_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output cmd_t     cmd
);

  logic known;

  assign in_ready = !q_full;

  always_comb begin
    known = 1'b1;
    cmd.op = OP_WRITE;
    case (in_data.mode)
      MODE_WRITE: cmd.op = OP_WRITE;
      MODE_START: cmd.op = OP_START;
      MODE_TICK:  cmd.op = OP_TICK;
      default:    known = 1'b0;
    endcase
    cmd.in_range = (int'(in_data.step_index) < MAX_STEPS) &&
                   (int'(in_data.column) < TABLE_COLUMNS);
    cmd.row  = in_data.step_index;
    cmd.col  = in_data.column;
    cmd.word = in_data.word;
  end

  // drop unused modes at the door
  assign push = in_valid && in_ready && known;

endmodule

[hdl/tpss_queue.sv]
module tpss_queue import tpss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (int'(count_r) == QUEUE_DEPTH);
  assign head    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hdl/tpss_back.sv]
module tpss_back import tpss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENTER = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_PEMIT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [15:0]       mem [MAX_STEPS * TABLE_COLUMNS];
  logic [15:0]       mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  logic [2:0]         state_r, state_nxt;
  logic               loaded_r, loaded_nxt;
  logic               running_r, running_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]  limit_r, limit_nxt;
  logic [PANEL_W-1:0] panel_r, panel_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               slot_free;
  logic [TIME_W-1:0]  el_inc;
  logic [CMP_W-1:0]   eff_steps, step_plus;
  logic [PANEL_W-1:0] lo, hi;
  logic [2:0]         sp;
  logic [1:0]         act;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;
  assign mem_waddr = tbl_addr(ROWX_W'(head.row), COLX_W'(head.col));

  always_comb begin
    el_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    if (cfg.step_count == '0) begin
      eff_steps = CMP_W'(1);
    end else if (CMP_W'(cfg.step_count) > CMP_W'(MAX_STEPS)) begin
      eff_steps = CMP_W'(MAX_STEPS);
    end else begin
      eff_steps = CMP_W'(cfg.step_count);
    end
    step_plus = CMP_W'(step_r) + 1'b1;
    lo = (cfg.first_panel == '0) ? PANEL_W'(1) : cfg.first_panel;
    hi = (int'(cfg.last_panel) > TABLE_COLUMNS - 1) ?
         PANEL_W'(TABLE_COLUMNS - 1) : cfg.last_panel;
    sp = (cfg.speed_level <= 3'd4) ? cfg.speed_level : 3'd0;
    if (mem_q_r == POS_NONE) begin
      act = ACT_DETACH;
    end else if (mem_q_r == POS_OPEN) begin
      act = ACT_OPEN;
    end else if (mem_q_r == POS_CLOSE) begin
      act = ACT_CLOSE;
    end else begin
      act = ACT_NO_MOVE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    running_nxt   = running_r;
    step_nxt      = step_r;
    elapsed_nxt   = elapsed_r;
    limit_nxt     = limit_r;
    panel_nxt     = panel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.op)
            OP_WRITE: begin
              mem_we      = head.in_range;
              loaded_nxt  = 1'b1;
              running_nxt = 1'b0;
              step_nxt    = '0;
              elapsed_nxt = '0;
              limit_nxt   = '0;
            end
            OP_START: begin
              if (loaded_r) begin
                running_nxt = 1'b1;
                step_nxt    = '0;
                state_nxt   = ST_ENTER;
              end
            end
            OP_TICK: begin
              if (running_r) begin
                elapsed_nxt = el_inc;
                if (el_inc > limit_r) begin
                  if (step_plus < eff_steps) begin
                    step_nxt  = step_r + 1'b1;
                    state_nxt = ST_ENTER;
                  end else begin
                    running_nxt = 1'b0;
                    loaded_nxt  = 1'b0;
                    step_nxt    = '0;
                    elapsed_nxt = '0;
                    limit_nxt   = '0;
                    state_nxt   = ST_DONE;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ENTER: begin
        mem_re    = 1'b1;
        mem_raddr = tbl_addr(ROWX_W'(step_r), '0);
        state_nxt = ST_LIMIT;
      end
      ST_LIMIT: begin
        limit_nxt   = (TIME_W'(mem_q_r) << 3) + (TIME_W'(mem_q_r) << 1);
        elapsed_nxt = '0;
        panel_nxt   = lo;
        if (lo > hi) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = tbl_addr(ROWX_W'(step_r), COLX_W'(lo));
          state_nxt = ST_PEMIT;
        end
      end
      ST_PEMIT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = KIND_PANEL;
          out_data_nxt.panel  = panel_r;
          out_data_nxt.action = act;
          out_data_nxt.speed  = sp;
          out_data_nxt.last   = (panel_r == hi);
          if (panel_r == hi) begin
            state_nxt = ST_IDLE;
          end else begin
            panel_nxt = panel_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = tbl_addr(ROWX_W'(step_r), COLX_W'(panel_r + 1'b1));
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = KIND_DONE;
          out_data_nxt.panel  = '0;
          out_data_nxt.action = ACT_NO_MOVE;
          out_data_nxt.speed  = '0;
          out_data_nxt.last   = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= 1'b0;
      running_r   <= 1'b0;
      step_r      <= '0;
      elapsed_r   <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      running_r   <= running_nxt;
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    panel_r    <= panel_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= head.word;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

endmodule

[hdl/timed_panel_step_sequencer_core.sv]
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (in_item_t)
// out      output     out_valid / out_ready out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A write, or a start or tick that enters no step, is handled in the idle state.
// Entering a step passes pop, duration read and limit load, then one panel word per
// cycle unless out stalls (single step table read port); completion adds ST_DONE.
// Reset is synchronous, active low; the step table is not cleared.
// A stalled output holds the back end; the 2-word queue then fills and drops in_ready.
module timed_panel_step_sequencer_core import tpss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t front_cmd, head;
  logic push, pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_count  <= 7'd1;
      cfg_r.first_panel <= 4'd1;
      cfg_r.last_panel  <= 4'd15;
      cfg_r.speed_level <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_COUNT:  cfg_r.step_count  <= cfg_data;
        CFG_FIRST_PANEL: cfg_r.first_panel <= cfg_data[3:0];
        CFG_LAST_PANEL:  cfg_r.last_panel  <= cfg_data[3:0];
        CFG_SPEED_LEVEL: cfg_r.speed_level <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  tpss_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  tpss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tpss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tpss_pkg::*;

  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam logic [15:0] POS_MID      = 16'd3;
  localparam int          GAP_MAX      = 18;
  localparam int          SETTLE       = 40;
  localparam int          TOTAL_ITEMS  = 310;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          MS_PER_UNIT  = 10;
  localparam int          TABLE_SIZE   = MAX_STEPS * TABLE_COLUMNS;
  localparam int          HOLD_CYCLES  = 300;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  timed_panel_step_sequencer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer copy kept by the testbench
  logic [15:0] step_words [TABLE_SIZE];
  bit          word_known [TABLE_SIZE];
  bit          seq_loaded  = 1'b0;
  bit          seq_running = 1'b0;
  int unsigned step_pos    = 0;
  int unsigned ms_elapsed  = 0;
  int unsigned ms_limit    = 0;
  logic [6:0]  reg_steps   = 7'd1;
  logic [3:0]  reg_first   = 4'd1;
  logic [3:0]  reg_last    = 4'd15;
  logic [2:0]  reg_speed   = 3'd1;

  out_item_t   actions_due [$];
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          sent_count    = 0;
  int          sink_hold     = 0;
  bit          in_gaps_on    = 1'b1;
  bit          out_stalls_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int slot_of(int row, int col);
    return row * TABLE_COLUMNS + col;
  endfunction

  function automatic int steps_in_use();
    int n;
    n = reg_steps;
    if (n == 0) n = 1;
    if (n > MAX_STEPS) n = MAX_STEPS;
    return n;
  endfunction

  function automatic int lo_panel();
    return (reg_first == 0) ? 1 : int'(reg_first);
  endfunction

  function automatic int hi_panel();
    return (reg_last > TABLE_COLUMNS - 1) ? TABLE_COLUMNS - 1 : int'(reg_last);
  endfunction

  function automatic void open_step();
    out_item_t   cmds [$];
    out_item_t   cmd;
    logic [15:0] code;
    logic [2:0]  spd;
    int          p;
    spd = (reg_speed <= 3'd4) ? reg_speed : 3'd0;
    ms_limit = step_words[slot_of(step_pos, 0)] * MS_PER_UNIT;
    ms_elapsed = 0;
    for (p = lo_panel(); p <= hi_panel() && cmds.size() < 15; p++) begin
      code = step_words[slot_of(step_pos, p)];
      cmd.kind = KIND_PANEL;
      cmd.panel = 4'(p);
      case (code)
        POS_NONE:  cmd.action = ACT_DETACH;
        POS_OPEN:  cmd.action = ACT_OPEN;
        POS_CLOSE: cmd.action = ACT_CLOSE;
        default:   cmd.action = ACT_NO_MOVE;
      endcase
      cmd.speed = spd;
      cmd.last = 1'b0;
      cmds.push_back(cmd);
    end
    if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
    foreach (cmds[i]) actions_due.push_back(cmds[i]);
  endfunction

  function automatic void stop_sequence();
    seq_running = 1'b0;
    step_pos = 0;
    ms_elapsed = 0;
    ms_limit = 0;
  endfunction

  function automatic void predict(in_item_t it);
    out_item_t done;
    case (it.mode)
      MODE_WRITE: begin
        if (it.step_index < MAX_STEPS && it.column < TABLE_COLUMNS) begin
          step_words[slot_of(int'(it.step_index), int'(it.column))] = it.word;
          word_known[slot_of(int'(it.step_index), int'(it.column))] = 1'b1;
        end
        seq_loaded = 1'b1;
        stop_sequence();
      end
      MODE_START: begin
        if (seq_loaded) begin
          seq_running = 1'b1;
          step_pos = 0;
          open_step();
        end
      end
      MODE_TICK: begin
        if (seq_running) begin
          if (ms_elapsed < ELAPSED_MAX) ms_elapsed++;
          if (ms_elapsed > ms_limit) begin
            if (step_pos + 1 < steps_in_use()) begin
              step_pos++;
              open_step();
            end else begin
              done = '0;
              done.kind = KIND_DONE;
              done.last = 1'b1;
              actions_due.push_back(done);
              seq_loaded = 1'b0;
              stop_sequence();
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t item_of(logic [1:0] mode, int row, int col, logic [15:0] w);
    in_item_t it;
    it.mode = mode;
    it.step_index = 6'(row);
    it.column = 4'(col);
    it.word = w;
    return it;
  endfunction

  function automatic logic [15:0] rand_duration();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(3, 6)) : 16'($urandom_range(0, 2));
  endfunction

  function automatic logic [15:0] rand_code();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) return 16'($urandom_range(0, 3));
    if (pick == 8) return 16'($urandom_range(4, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] word_for(int col);
    return (col == 0) ? rand_duration() : rand_code();
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // hold valid and payload until the word is taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
    sent_count++;
  endtask

  task automatic send_write(int row, int col, logic [15:0] w);
    send_item(item_of(MODE_WRITE, row, col, w));
  endtask

  task automatic send_op(logic [1:0] mode);
    send_item(item_of(mode, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (actions_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(int steps, int first, int last, int speed);
    if (seq_running) send_write(0, 0, rand_duration());
    drain();
    reg_write(CFG_STEP_COUNT, CFG_DATA_W'(steps));
    reg_write(CFG_FIRST_PANEL, CFG_DATA_W'(first));
    reg_write(CFG_LAST_PANEL, CFG_DATA_W'(last));
    reg_write(CFG_SPEED_LEVEL, CFG_DATA_W'(speed));
    cfg_valid <= 1'b0;
    reg_steps = 7'(steps);
    reg_first = 4'(first);
    reg_last = 4'(last);
    reg_speed = 3'(speed);
  endtask

  task automatic load_missing();
    int r;
    int p;
    for (r = 0; r < steps_in_use(); r++) begin
      if (!word_known[slot_of(r, 0)]) send_write(r, 0, rand_duration());
      for (p = lo_panel(); p <= hi_panel(); p++)
        if (!word_known[slot_of(r, p)]) send_write(r, p, rand_code());
    end
  endtask

  task automatic rewrite_any();
    int r;
    int c;
    r = $urandom_range(0, MAX_STEPS - 1);
    c = $urandom_range(0, TABLE_COLUMNS - 1);
    send_write(r, c, word_for(c));
  endtask

  task automatic test_ignored_items();
    send_op(MODE_START);
    send_op(MODE_TICK);
    send_op(MODE_SPARE);
  endtask

  task automatic test_single_step();
    set_config(0, 0, 5, 7);
    send_write(0, 0, 16'd0);
    send_write(0, 1, POS_NONE);
    send_write(0, 2, POS_OPEN);
    send_write(0, 3, POS_CLOSE);
    send_write(0, 4, POS_MID);
    send_write(0, 5, 16'hFFFF);
    send_op(MODE_TICK);
    send_op(MODE_START);
    send_op(MODE_START);
    send_op(MODE_TICK);
    send_op(MODE_START);
  endtask

  task automatic test_step_timing();
    set_config(2, 2, 3, 4);
    send_write(0, 0, 16'd1);
    send_write(1, 0, 16'd0);
    send_write(1, 2, POS_CLOSE);
    send_write(1, 3, POS_OPEN);
    send_op(MODE_START);
    repeat (MS_PER_UNIT + 2) send_op(MODE_TICK);
  endtask

  task automatic test_full_length();
    int r;
    // empty panel range, oversized step count
    set_config(127, 9, 2, 5);
    for (r = 0; r < MAX_STEPS; r++) send_write(r, 0, 16'd0);
    send_op(MODE_START);
    while (seq_running) send_op(MODE_TICK);
  endtask

  task automatic test_output_backpressure();
    set_config(3, 1, TABLE_COLUMNS - 1, 2);
    load_missing();
    drain();
    in_gaps_on = 1'b0;
    sink_hold = HOLD_CYCLES;
    send_op(MODE_START);
    while (seq_running) send_op(MODE_TICK);
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_sequences();
    int steps;
    int first;
    int last;
    int pick;
    while (sent_count < TOTAL_ITEMS) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) steps = 0;
      else steps = $urandom_range(1, 4);
      first = $urandom_range(0, 15);
      last = $urandom_range(0, 15);
      if (pick == 1) last = (first == 0) ? 0 : $urandom_range(0, first - 1);
      set_config(steps, first, last, $urandom_range(0, 7));
      load_missing();
      repeat ($urandom_range(1, 3)) rewrite_any();
      if ($urandom_range(0, 3) == 0) send_op(MODE_TICK);
      send_op(MODE_START);
      while (seq_running) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_op(MODE_SPARE);
        else if (pick == 1) send_op(MODE_START);
        else if (pick == 2) begin
          rewrite_any();
          send_op(MODE_START);
        end else send_op(MODE_TICK);
      end
      if ($urandom_range(0, 1) == 0) send_op(MODE_START);
      else send_op(MODE_TICK);
    end
  endtask

  // drop ready for a random number of cycles per word, or for a requested hold
  initial begin : result_sink
    int pause;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        pause = sink_hold;
        sink_hold = 0;
      end else begin
        pause = out_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && sink_hold == 0);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t due;
    if (rst_n && out_valid && out_ready) begin
      if (actions_due.size() == 0) begin
        note_error($sformatf("unexpected word: kind %0d panel %0d action %0d speed %0d last %0d",
                             out_data.kind, out_data.panel, out_data.action,
                             out_data.speed, out_data.last));
      end else begin
        due = actions_due.pop_front();
        if (out_data.kind !== due.kind || out_data.panel !== due.panel ||
            out_data.action !== due.action || out_data.speed !== due.speed ||
            out_data.last !== due.last)
          note_error($sformatf({"mismatch: expected kind %0d panel %0d action %0d ",
                                "speed %0d last %0d, got kind %0d panel %0d action %0d ",
                                "speed %0d last %0d"},
                               due.kind, due.panel, due.action, due.speed, due.last,
                               out_data.kind, out_data.panel, out_data.action,
                               out_data.speed, out_data.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_items();
    test_single_step();
    test_step_timing();
    test_full_length();
    test_output_backpressure();
    test_random_sequences();
    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
